>>> rtl/hrld_pkg.sv
// ----------------------------------------------------------------------------
// hrld_pkg
// Types, character codes and helpers shared by the hex record line decoder.
// ----------------------------------------------------------------------------
package hrld_pkg;

    localparam int MAX_LINE_BYTES_DEF = 16;
    localparam int ADDRESS_BITS_DEF   = 16;

    localparam int OUT_ADDR_W  = 16;
    localparam int OUT_COUNT_W = 5;

    localparam logic [7:0] CHAR_NUL   = 8'd0;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_F  = 8'h46;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_F  = 8'h66;
    localparam logic [7:0] HEX_TEN    = 8'd10;

    typedef enum logic [1:0] {
        PH_ADDR,
        PH_DATA,
        PH_CHECK,
        PH_IGNORE
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_COLON = 2'd1,
        ST_MISMATCH = 2'd2
    } line_status_t;

    typedef struct packed {
        logic                   is_status;
        logic [OUT_ADDR_W-1:0]  byte_address;
        logic [7:0]             data_byte;
        logic [1:0]             line_status;
        logic [OUT_COUNT_W-1:0] byte_count;
        logic                   checksum_checked;
    } result_t;

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            v = c - CHAR_ZERO;
        end else if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
            v = c - CHAR_UC_A + HEX_TEN;
        end else if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
            v = c - CHAR_LC_A + HEX_TEN;
        end
        return v[3:0];
    endfunction

    function automatic logic is_terminator(input logic [7:0] c);
        return (c == CHAR_CR) || (c == CHAR_LF) || (c == CHAR_NUL);
    endfunction

endpackage

>>> rtl/hrld_parser.sv
// ----------------------------------------------------------------------------
// hrld_parser
// Per-character line parser: line state registers and result formation.
// ----------------------------------------------------------------------------
module hrld_parser
    import hrld_pkg::*;
#(
    parameter int MAX_LINE_BYTES = MAX_LINE_BYTES_DEF,
    parameter int ADDRESS_BITS   = ADDRESS_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] char_code,
    output logic       res_valid,
    output result_t    res
);

    localparam int IDX_W = $clog2(MAX_LINE_BYTES + 1);

    phase_t                  phase_reg, phase_next;
    logic [ADDRESS_BITS-1:0] line_address_reg, line_address_next;
    logic [IDX_W-1:0]        byte_index_reg, byte_index_next;
    logic [3:0]              high_nibble_reg, high_nibble_next;
    logic                    nibble_pending_reg, nibble_pending_next;
    logic [7:0]              running_xor_reg, running_xor_next;
    logic [1:0]              check_seen_reg, check_seen_next;
    logic [7:0]              received_check_reg, received_check_next;
    logic                    line_nonempty_reg, line_nonempty_next;

    logic [3:0]              nib;
    logic [7:0]              pair_byte;
    logic [ADDRESS_BITS-1:0] data_addr;
    logic [31:0]             addr_ext;
    logic [31:0]             line_addr_ext;
    logic [31:0]             idx_ext;
    logic                    line_full;

    assign nib           = hex_nibble(char_code);
    assign pair_byte     = {high_nibble_reg, nib};
    assign data_addr     = line_address_reg + ADDRESS_BITS'(byte_index_reg);
    assign addr_ext      = 32'(data_addr);
    assign line_addr_ext = 32'(line_address_reg);
    assign idx_ext       = 32'(byte_index_reg);
    assign line_full     = idx_ext >= 32'(MAX_LINE_BYTES);

    always_comb begin
        phase_next          = phase_reg;
        line_address_next   = line_address_reg;
        byte_index_next     = byte_index_reg;
        high_nibble_next    = high_nibble_reg;
        nibble_pending_next = nibble_pending_reg;
        running_xor_next    = running_xor_reg;
        check_seen_next     = check_seen_reg;
        received_check_next = received_check_reg;
        line_nonempty_next  = line_nonempty_reg;
        res_valid           = 1'b0;
        res                 = '0;

        if (is_terminator(char_code)) begin
            res_valid            = line_nonempty_reg;
            res.is_status        = 1'b1;
            res.byte_address     = line_addr_ext[OUT_ADDR_W-1:0];
            if (phase_reg == PH_ADDR) begin
                res.line_status = ST_NO_COLON;
            end else begin
                res.byte_count = idx_ext[OUT_COUNT_W-1:0];
                if (check_seen_reg >= 2'd2) begin
                    res.checksum_checked = 1'b1;
                    if (received_check_reg != running_xor_reg) begin
                        res.line_status = ST_MISMATCH;
                    end
                end
            end
            phase_next          = PH_ADDR;
            line_address_next   = '0;
            byte_index_next     = '0;
            high_nibble_next    = '0;
            nibble_pending_next = 1'b0;
            running_xor_next    = '0;
            check_seen_next     = '0;
            received_check_next = '0;
            line_nonempty_next  = 1'b0;
        end else begin
            line_nonempty_next = 1'b1;
            unique case (phase_reg)
                PH_ADDR: begin
                    if (char_code == CHAR_COLON) begin
                        phase_next = PH_DATA;
                    end else begin
                        line_address_next = {line_address_reg[ADDRESS_BITS-5:0], nib};
                    end
                end
                PH_DATA: begin
                    if (!nibble_pending_reg) begin
                        if (char_code == CHAR_COMMA) begin
                            phase_next = PH_CHECK;
                        end else if (line_full) begin
                            phase_next = PH_IGNORE;
                        end else begin
                            high_nibble_next    = nib;
                            nibble_pending_next = 1'b1;
                        end
                    end else begin
                        nibble_pending_next = 1'b0;
                        running_xor_next    = running_xor_reg ^ pair_byte;
                        byte_index_next     = byte_index_reg + IDX_W'(1);
                        res_valid           = 1'b1;
                        res.byte_address    = addr_ext[OUT_ADDR_W-1:0];
                        res.data_byte       = pair_byte;
                    end
                end
                PH_CHECK: begin
                    if (check_seen_reg == 2'd0) begin
                        high_nibble_next = nib;
                        check_seen_next  = 2'd1;
                    end else if (check_seen_reg == 2'd1) begin
                        received_check_next = pair_byte;
                        check_seen_next     = 2'd2;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_ADDR;
            line_address_reg   <= '0;
            byte_index_reg     <= '0;
            high_nibble_reg    <= '0;
            nibble_pending_reg <= 1'b0;
            running_xor_reg    <= '0;
            check_seen_reg     <= '0;
            received_check_reg <= '0;
            line_nonempty_reg  <= 1'b0;
        end else if (step) begin
            phase_reg          <= phase_next;
            line_address_reg   <= line_address_next;
            byte_index_reg     <= byte_index_next;
            high_nibble_reg    <= high_nibble_next;
            nibble_pending_reg <= nibble_pending_next;
            running_xor_reg    <= running_xor_next;
            check_seen_reg     <= check_seen_next;
            received_check_reg <= received_check_next;
            line_nonempty_reg  <= line_nonempty_next;
        end
    end

    a_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_ext <= 32'(MAX_LINE_BYTES))
        else $error("byte index past line limit");

    a_pending_only_in_data: assert property (@(posedge aclk) disable iff (!aresetn)
        nibble_pending_reg |-> phase_reg == PH_DATA)
        else $error("pending nibble outside data phase");

    a_data_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res_valid && !res.is_status |-> !line_full)
        else $error("data word emitted on a full line");

endmodule

>>> rtl/hrld_out_fifo.sv
// ----------------------------------------------------------------------------
// hrld_out_fifo
// Two-entry result buffer that decouples the parser from the receiver.
// ----------------------------------------------------------------------------
module hrld_out_fifo
    import hrld_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    wr_en,
    input  result_t wr_data,
    output logic    wr_ready,
    output logic    rd_valid,
    input  logic    rd_ready,
    output result_t rd_data
);

    result_t    mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       rd_en;

    assign wr_ready = count_reg != 2'd2;
    assign rd_valid = count_reg != 2'd0;
    assign rd_en    = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd_en) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'd2)
        else $error("result buffer count out of range");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> count_reg != 2'd2)
        else $error("write into full result buffer");

    a_ptr_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("buffer pointers disagree with count");

endmodule

>>> rtl/hex_record_line_decoder.sv
// ----------------------------------------------------------------------------
// hex_record_line_decoder
// Decodes ASCII lines of the form address:hexpairs,checksum, one character
// per word, into data byte words and end-of-line status words.
//
// s_ channel: one character per word in s_char_code (CR, LF or NUL ends a
// line). m_ channel: one result word with m_is_status telling a data byte
// from a line status; most characters give no result.
// A character is held in an input register, parsed once the result buffer
// has room, and its result, if any, is written into a two-entry result
// buffer whose oldest word is presented on m_. Throughput is one character
// per cycle while the buffer has room; the line state update is a single
// register-to-register pass through the parser.
// After reset the line state is cleared and the parser waits for an address.
// When the receiver stalls, results collect in the buffer; once it is full
// the parser holds and s_ready drops after the input register fills.
// ----------------------------------------------------------------------------
module hex_record_line_decoder
    import hrld_pkg::*;
#(
    parameter int MAX_LINE_BYTES = MAX_LINE_BYTES_DEF,
    parameter int ADDRESS_BITS   = ADDRESS_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_char_code,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_is_status,
    output logic [OUT_ADDR_W-1:0]  m_byte_address,
    output logic [7:0]             m_data_byte,
    output logic [1:0]             m_line_status,
    output logic [OUT_COUNT_W-1:0] m_byte_count,
    output logic                   m_checksum_checked
);

    logic       in_valid_reg;
    logic [7:0] char_reg;
    logic       step;
    logic       res_valid;
    result_t    res;
    logic       fifo_ready;
    result_t    out_word;

    assign step    = in_valid_reg && fifo_ready;
    assign s_ready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            char_reg <= s_char_code;
        end
    end

    hrld_parser #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES),
        .ADDRESS_BITS   (ADDRESS_BITS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .char_code (char_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    hrld_out_fifo u_out_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (step && res_valid),
        .wr_data  (res),
        .wr_ready (fifo_ready),
        .rd_valid (m_valid),
        .rd_ready (m_ready),
        .rd_data  (out_word)
    );

    assign m_is_status        = out_word.is_status;
    assign m_byte_address     = out_word.byte_address;
    assign m_data_byte        = out_word.data_byte;
    assign m_line_status      = out_word.line_status;
    assign m_byte_count       = out_word.byte_count;
    assign m_checksum_checked = out_word.checksum_checked;

endmodule

>>> verif/hex_record_line_decoder_test.sv
// ----------------------------------------------------------------------------
// hex_record_line_decoder_test
// Self-checking bench for the hex record line decoder. A short directed table
// (empty line, missing colon, address wrap, checksum mismatch, junk as the low
// nibble, odd trailing nibble) runs first, then random record lines: mostly
// well-formed with random content, some truncated, overlong or junk-filled.
// Every accepted character is run through an in-bench line parser and each
// result word is compared field by field with the oldest expected word.
// The sender idles in random bursts, and the receiver stalls in changing
// patterns.
// ----------------------------------------------------------------------------
module hex_record_line_decoder_test
    import hrld_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 700;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic [7:0] code;
        bit         typed;
        result_t    want;
    } stim_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [7:0]             s_char_code = 8'd0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_is_status;
    logic [OUT_ADDR_W-1:0]  m_byte_address;
    logic [7:0]             m_data_byte;
    logic [1:0]             m_line_status;
    logic [OUT_COUNT_W-1:0] m_byte_count;
    logic                   m_checksum_checked;

    // line parser state
    phase_t      cur_phase;
    logic [15:0] cur_addr;
    logic [4:0]  cur_index;
    logic [3:0]  held_nibble;
    bit          nibble_waiting;
    logic [7:0]  xor_acc;
    logic [1:0]  check_chars;
    logic [7:0]  check_value;
    bit          line_started;

    result_t   pending_words[$];
    stim_row_t directed_rows[$];
    int        items_sent = 0;
    int        burst_left = 0;
    int        fault_count = 0;
    int        stall_cycles = 0;
    int        rx_mode = 0;
    int        rx_left = 0;
    int        rx_tick = 0;

    hex_record_line_decoder dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_char_code        (s_char_code),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_is_status        (m_is_status),
        .m_byte_address     (m_byte_address),
        .m_data_byte        (m_data_byte),
        .m_line_status      (m_line_status),
        .m_byte_count       (m_byte_count),
        .m_checksum_checked (m_checksum_checked)
    );

    always #1 aclk = ~aclk;

    function automatic logic [3:0] nibble_value(input logic [7:0] c);
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            return c[3:0];
        end
        if ((c >= CHAR_UC_A && c <= CHAR_UC_F) || (c >= CHAR_LC_A && c <= CHAR_LC_F)) begin
            return c[3:0] + 4'd9;
        end
        return 4'd0;
    endfunction

    function automatic result_t data_word(input logic [15:0] a, input logic [7:0] b);
        result_t w;
        w = '0;
        w.byte_address = a;
        w.data_byte = b;
        return w;
    endfunction

    function automatic result_t status_word(input logic [15:0] a, input line_status_t st,
                                            input logic [4:0] n, input logic chk);
        result_t w;
        w = '0;
        w.is_status = 1'b1;
        w.byte_address = a;
        w.line_status = st;
        w.byte_count = n;
        w.checksum_checked = chk;
        return w;
    endfunction

    function automatic stim_row_t plain_row(input logic [7:0] c);
        stim_row_t r;
        r.code = c;
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic stim_row_t word_row(input logic [7:0] c, input result_t w);
        stim_row_t r;
        r.code = c;
        r.typed = 1'b1;
        r.want = w;
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) begin
            return CHAR_ZERO + v;
        end
        return ($urandom_range(0, 1) ? CHAR_UC_A : CHAR_LC_A) + v - HEX_TEN;
    endfunction

    function automatic logic [7:0] random_junk();
        logic [7:0] c;
        c = CHAR_COLON;
        while (c == CHAR_CR || c == CHAR_LF || c == CHAR_COLON || c == CHAR_COMMA) begin
            c = 8'($urandom_range(1, 255));
        end
        return c;
    endfunction

    function automatic logic [7:0] pick_terminator();
        case ($urandom_range(0, 2))
            0: begin
                return CHAR_CR;
            end
            1: begin
                return CHAR_LF;
            end
            default: begin
                return CHAR_NUL;
            end
        endcase
    endfunction

    task automatic clear_line_state();
        cur_phase = PH_ADDR;
        cur_addr = '0;
        cur_index = '0;
        held_nibble = '0;
        nibble_waiting = 1'b0;
        xor_acc = '0;
        check_chars = '0;
        check_value = '0;
        line_started = 1'b0;
    endtask

    task automatic decode_char(input logic [7:0] c, output bit has_word, output result_t word);
        logic [7:0]   b;
        bit           chk;
        line_status_t st;
        has_word = 1'b0;
        word = '0;
        if (c == CHAR_CR || c == CHAR_LF || c == CHAR_NUL) begin
            if (line_started) begin
                has_word = 1'b1;
                if (cur_phase == PH_ADDR) begin
                    word = status_word(cur_addr, ST_NO_COLON, 5'd0, 1'b0);
                end else begin
                    chk = (check_chars == 2'd2);
                    st = (chk && check_value != xor_acc) ? ST_MISMATCH : ST_OK;
                    word = status_word(cur_addr, st, cur_index, chk);
                end
            end
            clear_line_state();
            return;
        end
        line_started = 1'b1;
        case (cur_phase)
            PH_ADDR: begin
                if (c == CHAR_COLON) begin
                    cur_phase = PH_DATA;
                end else begin
                    cur_addr = {cur_addr[11:0], nibble_value(c)};
                end
            end
            PH_DATA: begin
                if (!nibble_waiting) begin
                    if (c == CHAR_COMMA) begin
                        cur_phase = PH_CHECK;
                    end else if (cur_index >= MAX_LINE_BYTES_DEF) begin
                        cur_phase = PH_IGNORE;
                    end else begin
                        held_nibble = nibble_value(c);
                        nibble_waiting = 1'b1;
                    end
                end else begin
                    b = {held_nibble, nibble_value(c)};
                    has_word = 1'b1;
                    word = data_word(cur_addr + 16'(cur_index), b);
                    xor_acc ^= b;
                    cur_index++;
                    nibble_waiting = 1'b0;
                end
            end
            PH_CHECK: begin
                if (check_chars == 2'd0) begin
                    held_nibble = nibble_value(c);
                    check_chars = 2'd1;
                end else if (check_chars == 2'd1) begin
                    check_value = {held_nibble, nibble_value(c)};
                    check_chars = 2'd2;
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_char(input logic [7:0] c, input bit typed, input result_t typed_word);
        bit      has_word;
        result_t word;
        int      gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 20);
            gap = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_char_code <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        decode_char(c, has_word, word);
        if (typed) begin
            pending_words.push_back(typed_word);
        end else if (has_word) begin
            pending_words.push_back(word);
        end
        items_sent++;
    endtask

    task automatic send_plain(input logic [7:0] c);
        send_char(c, 1'b0, '0);
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_words.size() != 0) @(posedge aclk);
    endtask

    task automatic send_line();
        int         kind;
        int         n;
        int         ck;
        int         k;
        logic [7:0] xsum;
        logic [7:0] b;
        logic [7:0] c;
        xsum = '0;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            n = $urandom_range(1, 12);
            for (k = 0; k < n; k++) begin
                send_plain(8'($urandom_range(0, 255)));
            end
        end else if (kind == 1) begin
            n = $urandom_range(1, 8);
            for (k = 0; k < n; k++) begin
                send_plain(random_junk());
            end
            send_plain(pick_terminator());
        end else begin
            n = $urandom_range(0, 6);
            for (k = 0; k < n; k++) begin
                send_plain(($urandom_range(0, 9) == 0) ? random_junk()
                                                       : hex_char(4'($urandom_range(0, 15))));
            end
            send_plain(CHAR_COLON);
            case ($urandom_range(0, 9))
                7: begin
                    n = $urandom_range(5, 15);
                end
                8: begin
                    n = MAX_LINE_BYTES_DEF;
                end
                9: begin
                    n = $urandom_range(MAX_LINE_BYTES_DEF + 1, MAX_LINE_BYTES_DEF + 3);
                end
                default: begin
                    n = $urandom_range(0, 4);
                end
            endcase
            for (k = 0; k < n; k++) begin
                b = 8'($urandom_range(0, 255));
                send_plain(hex_char(b[7:4]));
                if ($urandom_range(0, 11) == 0) begin
                    case ($urandom_range(0, 3))
                        0: begin
                            c = CHAR_COLON;
                        end
                        1: begin
                            c = CHAR_COMMA;
                        end
                        default: begin
                            c = random_junk();
                        end
                    endcase
                    b[3:0] = nibble_value(c);
                end else begin
                    c = hex_char(b[3:0]);
                end
                send_plain(c);
                if (k < MAX_LINE_BYTES_DEF) begin
                    xsum ^= b;
                end
            end
            ck = $urandom_range(0, 5);
            if (ck == 0 && $urandom_range(0, 2) == 0) begin
                send_plain(hex_char(4'($urandom_range(0, 15))));
            end
            if (ck >= 1) begin
                send_plain(CHAR_COMMA);
            end
            if (ck == 2) begin
                send_plain(hex_char(4'($urandom_range(0, 15))));
            end
            if (ck >= 3) begin
                b = (ck == 3) ? (xsum ^ 8'($urandom_range(1, 255))) : xsum;
                send_plain(hex_char(b[7:4]));
                send_plain(hex_char(b[3:0]));
                if ($urandom_range(0, 3) == 0) begin
                    n = $urandom_range(1, 3);
                    for (k = 0; k < n; k++) begin
                        send_plain(random_junk());
                    end
                end
            end
            send_plain(pick_terminator());
            if ($urandom_range(0, 9) == 0) begin
                send_plain(pick_terminator());
            end
        end
    endtask

    // receiver stall pattern
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(64, 256);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= ($urandom_range(0, 3) != 0);
            end
            2: begin
                m_ready <= (rx_tick % 8 == 0);
            end
            default: begin
                m_ready <= (rx_tick % 48 >= 40);
            end
        endcase
    end

    // result word check
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            got.is_status = m_is_status;
            got.byte_address = m_byte_address;
            got.data_byte = m_data_byte;
            got.line_status = m_line_status;
            got.byte_count = m_byte_count;
            got.checksum_checked = m_checksum_checked;
            if (pending_words.size() == 0) begin
                fault_count++;
                if (fault_count <= 10) begin
                    $display("unexpected word: status=%0b addr=%h data=%h st=%0d cnt=%0d chk=%0b",
                             got.is_status, got.byte_address, got.data_byte,
                             got.line_status, got.byte_count, got.checksum_checked);
                end
            end else begin
                want = pending_words.pop_front();
                if (got.is_status !== want.is_status || got.byte_address !== want.byte_address
                        || got.data_byte !== want.data_byte
                        || got.line_status !== want.line_status
                        || got.byte_count !== want.byte_count
                        || got.checksum_checked !== want.checksum_checked) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("mismatch exp: status=%0b addr=%h data=%h st=%0d cnt=%0d chk=%0b",
                                 want.is_status, want.byte_address, want.data_byte,
                                 want.line_status, want.byte_count, want.checksum_checked);
                        $display("         got: status=%0b addr=%h data=%h st=%0d cnt=%0d chk=%0b",
                                 got.is_status, got.byte_address, got.data_byte,
                                 got.line_status, got.byte_count, got.checksum_checked);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        clear_line_state();

        // empty line, then a line with no colon
        directed_rows.push_back(plain_row(CHAR_CR));
        directed_rows.push_back(plain_row("G"));
        directed_rows.push_back(word_row(CHAR_LF, status_word(16'h0000, ST_NO_COLON, 5'd0, 1'b0)));
        // address overflow keeps low bits, byte at top of space, wrong checksum
        repeat (5) directed_rows.push_back(plain_row("F"));
        directed_rows.push_back(plain_row(CHAR_COLON));
        directed_rows.push_back(plain_row("9"));
        directed_rows.push_back(word_row("9", data_word(16'hFFFF, 8'h99)));
        directed_rows.push_back(plain_row(CHAR_COMMA));
        directed_rows.push_back(plain_row("0"));
        directed_rows.push_back(plain_row("0"));
        directed_rows.push_back(word_row(CHAR_CR, status_word(16'hFFFF, ST_MISMATCH, 5'd1, 1'b1)));
        // comma as low nibble counts as zero
        directed_rows.push_back(plain_row(CHAR_COLON));
        directed_rows.push_back(plain_row("1"));
        directed_rows.push_back(word_row(CHAR_COMMA, data_word(16'h0000, 8'h10)));
        directed_rows.push_back(word_row(CHAR_LF, status_word(16'h0000, ST_OK, 5'd1, 1'b0)));
        // lone trailing nibble dropped
        directed_rows.push_back(plain_row(CHAR_COLON));
        directed_rows.push_back(plain_row("7"));
        directed_rows.push_back(word_row(CHAR_NUL, status_word(16'h0000, ST_OK, 5'd0, 1'b0)));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_char(directed_rows[i].code, directed_rows[i].typed, directed_rows[i].want);
        end
        hold_until_drained();

        while (items_sent < directed_rows.size() + RANDOM_ITEMS) begin
            send_line();
            if ($urandom_range(0, 19) == 0) begin
                hold_until_drained();
            end
        end

        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fault_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
